// ===== rtl/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and register codes of the pulse-distance IR
// frame receiver.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int unsigned INTERVAL_BITS   = 20;
  localparam int unsigned BYTES_PER_FRAME = 5;
  localparam int unsigned STORE_DEPTH     = BYTES_PER_FRAME - 1;
  localparam int unsigned STORE_IDX_BITS  = $clog2(STORE_DEPTH);
  localparam int unsigned BYTE_IDX_BITS   = 3;

  localparam int unsigned IN_TDATA_BITS   = ((INTERVAL_BITS + 7) / 8) * 8;
  localparam int unsigned RES_BITS        = 43;
  localparam int unsigned OUT_TDATA_BITS  = ((RES_BITS + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_BITS    = 3;

  typedef logic [INTERVAL_BITS-1:0] interval_t;

  localparam interval_t GAP_RESET   = interval_t'(20000);
  localparam interval_t START_RESET = interval_t'(2750);
  localparam interval_t END_RESET   = interval_t'(1500);
  localparam interval_t ONE_RESET   = interval_t'(1120);
  localparam interval_t ZERO_RESET  = interval_t'(750);

  localparam logic [7:0] BAD_ACK  = 8'hFF;
  localparam logic [7:0] ONE_BIT  = 8'h80;

  localparam logic [BYTE_IDX_BITS-1:0] LAST_BYTE_IDX = BYTE_IDX_BITS'(BYTES_PER_FRAME - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO  = 3'd4;

  typedef enum logic [1:0] {
    EDGE_IGNORE,
    EDGE_END,
    EDGE_ONE,
    EDGE_ZERO
  } edge_kind_e;

  typedef struct packed {
    interval_t gap;
    interval_t start;
    interval_t stop;
    interval_t one;
    interval_t zero;
  } thresholds_t;

  typedef struct packed {
    logic       gap;
    edge_kind_e kind;
  } edge_class_t;

  typedef struct packed {
    logic       ack_twice;
    logic [7:0] ack_byte;
    logic       is_new;
    logic       checksum_ok;
    logic [7:0] payload_third;
    logic [7:0] payload_second;
    logic [7:0] payload_first;
    logic [7:0] frame_id;
  } frame_result_t;

endpackage

// ===== rtl/irpd_classify.sv =====
// ----------------------------------------------------------------------------
// irpd_classify
// Sorts one edge interval against the five thresholds.
// ----------------------------------------------------------------------------
module irpd_classify import irpd_pkg::*; (
  input  interval_t   interval_i,
  input  thresholds_t thr_i,
  output edge_class_t class_o
);

  always_comb begin
    class_o.gap = (interval_i > thr_i.gap);
    priority if (interval_i > thr_i.start) begin
      class_o.kind = EDGE_IGNORE;
    end else if (interval_i > thr_i.stop) begin
      class_o.kind = EDGE_END;
    end else if (interval_i > thr_i.one) begin
      class_o.kind = EDGE_ONE;
    end else if (interval_i > thr_i.zero) begin
      class_o.kind = EDGE_ZERO;
    end else begin
      class_o.kind = EDGE_IGNORE;
    end
  end

endmodule

// ===== rtl/ir_pulse_distance_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_receiver_unit
// Pulse-distance infrared frame receiver: edge intervals in, decoded
// five-byte frames with checksum verdict and acknowledge byte out.
// ----------------------------------------------------------------------------
// Feed one item per falling edge of the receive line, holding the time since
// the previous edge. The block takes one item every clock cycle while its output
// queue has room: an item is registered, classified and applied to the frame
// state in the next cycle; the item that ends the fifth byte pushes the result.
// Results wait in a two-entry output queue (result register plus skid), so input
// flows on while a result stalls; input stops only once both entries are claimed.
// The user writes thresholds through the cfg port while the block is idle, which
// the block does not enforce; cfg_ready_o is always high, unknown indexes dropped.
module ir_pulse_distance_frame_receiver_unit import irpd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // interval items
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,   // [19:0] edge_interval
  // frame results
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [7:0] frame_id, [15:8] payload_first, [23:16] payload_second,
  // [31:24] payload_third, [32] checksum_ok, [33] is_new, [41:34] ack_byte,
  // [42] ack_twice, rest zero
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  // configuration writes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [INTERVAL_BITS-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Threshold registers
  // --------------------------------------------------------------------------
  thresholds_t thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.gap   <= GAP_RESET;
      thr_q.start <= START_RESET;
      thr_q.stop  <= END_RESET;
      thr_q.one   <= ONE_RESET;
      thr_q.zero  <= ZERO_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GAP:   thr_q.gap   <= cfg_data_i;
        CFG_START: thr_q.start <= cfg_data_i;
        CFG_END:   thr_q.stop  <= cfg_data_i;
        CFG_ONE:   thr_q.one   <= cfg_data_i;
        CFG_ZERO:  thr_q.zero  <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output queue bookkeeping and input credit
  // --------------------------------------------------------------------------
  logic          out_vld_q, skid_vld_q;
  frame_result_t out_q, skid_q;
  logic          in_vld_q;
  interval_t     in_q;
  logic          pop;
  logic          res_push;
  logic [1:0]    claimed;

  assign pop = out_vld_q & m_axis_tready_i;

  // Entries held after this cycle's pop and push. Accept only if one entry
  // stays free for the item that then sits in the input register.
  assign claimed = 2'(out_vld_q) + 2'(skid_vld_q) + 2'(res_push) - 2'(pop);
  assign s_axis_tready_o = (claimed <= 2'd1);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= s_axis_tvalid_i & s_axis_tready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= s_axis_tdata_i[INTERVAL_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Classify and update frame state
  // --------------------------------------------------------------------------
  edge_class_t cls;

  irpd_classify u_classify (
    .interval_i (in_q),
    .thr_i      (thr_q),
    .class_o    (cls)
  );

  logic [BYTE_IDX_BITS-1:0]  byte_idx_q, byte_idx_d, byte_idx_eff;
  logic [7:0]                bit_shift_q, bit_shift_d;
  logic [7:0]                last_id_q, last_id_d;
  logic [7:0]                store_q [STORE_DEPTH];
  logic                      store_we;
  logic [7:0]                sum;
  logic                      sum_ok;
  frame_result_t             res;

  // a long gap restarts the frame before the edge itself is judged
  assign byte_idx_eff = cls.gap ? '0 : byte_idx_q;

  assign sum    = store_q[0] + store_q[1] + store_q[2] + store_q[3];
  assign sum_ok = (sum == bit_shift_q);

  always_comb begin
    res.frame_id       = store_q[0];
    res.payload_first  = store_q[1];
    res.payload_second = store_q[2];
    res.payload_third  = store_q[3];
    res.checksum_ok    = sum_ok;
    res.is_new         = sum_ok & (store_q[0] != last_id_q);
    res.ack_byte       = sum_ok ? sum : BAD_ACK;
    res.ack_twice      = sum_ok & (store_q[0] == last_id_q);
  end

  always_comb begin
    byte_idx_d  = byte_idx_q;
    bit_shift_d = bit_shift_q;
    last_id_d   = last_id_q;
    store_we    = 1'b0;
    res_push    = 1'b0;
    if (in_vld_q) begin
      byte_idx_d = byte_idx_eff;
      unique case (cls.kind)
        EDGE_END: begin
          bit_shift_d = '0;
          if (byte_idx_eff >= LAST_BYTE_IDX) begin
            // fifth byte comes straight from the shifter: emit the frame
            res_push   = 1'b1;
            byte_idx_d = '0;
            if (sum_ok) begin
              last_id_d = store_q[0];
            end
          end else begin
            store_we   = 1'b1;
            byte_idx_d = byte_idx_eff + 1'b1;
          end
        end
        EDGE_ONE:    bit_shift_d = (bit_shift_q >> 1) | ONE_BIT;
        EDGE_ZERO:   bit_shift_d = bit_shift_q >> 1;
        EDGE_IGNORE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= '0;
      bit_shift_q <= '0;
      last_id_q   <= '0;
    end else begin
      byte_idx_q  <= byte_idx_d;
      bit_shift_q <= bit_shift_d;
      last_id_q   <= last_id_d;
    end
  end

  // frame bytes hold no reset: each entry is written before a frame reads it
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[byte_idx_eff[STORE_IDX_BITS-1:0]] <= bit_shift_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: result register with skid entry behind it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !pop) begin
      // hold the head; park a new result in the skid entry
      if (res_push) begin
        skid_vld_q <= 1'b1;
      end
    end else begin
      // head is free: advance the skid entry or take the new result
      out_vld_q  <= skid_vld_q | res_push;
      skid_vld_q <= skid_vld_q & res_push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !pop) begin
      if (res_push) begin
        skid_q <= res;
      end
    end else begin
      out_q  <= skid_vld_q ? skid_q : res;
      if (skid_vld_q && res_push) begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_BITS'(out_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while result register empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !(out_vld_q && skid_vld_q))
    else $error("result produced with output queue full");

  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q <= LAST_BYTE_IDX)
    else $error("byte index beyond last frame byte");

  a_result_resets_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> (byte_idx_q == '0) && (bit_shift_q == '0))
    else $error("frame state not restarted after result");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pulse-distance IR frame receiver. A queue of
// edge intervals feeds a stream driver, a monitor predicts the decoded
// frames and checks every result item field by field, and the run walks
// through default, random, tight, out-of-order and extreme thresholds.
// ----------------------------------------------------------------------------
module testbench;
  import irpd_pkg::*;

  localparam int        HALF_PERIOD  = 2;
  localparam int        RESET_CYCLES = 9;
  localparam int        DRAIN_CYCLES = 8;     // extra wait for items that cause no result
  localparam int        QUIET_LIMIT  = 5000;  // cycles without any handshake
  localparam int        LONG_HOLD    = 400;   // receiver hold-off, enough to fill the block
  localparam int        REPORT_LIMIT = 10;
  localparam interval_t IV_MAX       = '1;

  // kinds of interval the stimulus asks for, relative to the current thresholds
  typedef enum int {MK_GAP, MK_START, MK_END, MK_ONE, MK_ZERO, MK_LOW} mark_e;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i  = '0;   // [19:0] edge_interval
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  // [7:0] frame_id, [15:8] payload_first, [23:16] payload_second,
  // [31:24] payload_third, [32] checksum_ok, [33] is_new, [41:34] ack_byte,
  // [42] ack_twice, rest zero
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i     = '0;
  logic [INTERVAL_BITS-1:0]  cfg_data_i      = '0;

  ir_pulse_distance_frame_receiver_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // stimulus side
  interval_t   interval_q [$];
  int          pushed_cnt   = 0;
  int          tx_idle_pct  = 7;
  int          rx_idle_pct  = 82;
  int          hold_req     = 0;
  logic [7:0]  prev_frame [BYTES_PER_FRAME] = '{default: '0};

  // monitor side
  int          accepted_cnt = 0;
  logic        in_taken     = 1'b0;
  int          err_cnt      = 0;
  int          hold_ack     = 0;
  int          hold_left    = 0;
  int          quiet_cycles = 0;

  // decoder copy: thresholds, shift register, byte index, stored bytes, last id
  thresholds_t                thr = {GAP_RESET, START_RESET, END_RESET, ONE_RESET, ZERO_RESET};
  logic [7:0]                 rx_shift   = '0;
  logic [BYTE_IDX_BITS-1:0]   rx_index   = '0;
  logic [7:0]                 rx_bytes [STORE_DEPTH] = '{default: '0};
  logic [7:0]                 rx_last_id = '0;
  frame_result_t              pending_frames [$];

  // --------------------------------------------------------------------------
  // Frame decoder prediction
  // --------------------------------------------------------------------------
  function automatic edge_kind_e classify_interval(input interval_t t);
    if (t > thr.start) return EDGE_IGNORE;   // start mark
    if (t > thr.stop)  return EDGE_END;
    if (t > thr.one)   return EDGE_ONE;
    if (t > thr.zero)  return EDGE_ZERO;
    return EDGE_IGNORE;                      // too short to count
  endfunction

  task automatic decode_interval(input interval_t t);
    edge_kind_e    kind;
    frame_result_t res;
    logic [7:0]    sum;
    // a frame gap restarts the byte count whatever the interval means otherwise
    if (t > thr.gap) rx_index = '0;
    kind = classify_interval(t);
    case (kind)
      EDGE_END: begin
        if (rx_index >= LAST_BYTE_IDX) begin
          // fifth byte comes straight from the shift register
          sum                = rx_bytes[0] + rx_bytes[1] + rx_bytes[2] + rx_bytes[3];
          res                = '0;
          res.frame_id       = rx_bytes[0];
          res.payload_first  = rx_bytes[1];
          res.payload_second = rx_bytes[2];
          res.payload_third  = rx_bytes[3];
          res.checksum_ok    = (sum == rx_shift);
          res.is_new         = res.checksum_ok && (rx_bytes[0] != rx_last_id);
          res.ack_byte       = res.checksum_ok ? sum : BAD_ACK;
          res.ack_twice      = res.checksum_ok && !res.is_new;
          if (res.checksum_ok) rx_last_id = rx_bytes[0];
          rx_index = '0;
          pending_frames.push_back(res);
        end else begin
          rx_bytes[rx_index[STORE_IDX_BITS-1:0]] = rx_shift;
          rx_index = rx_index + 1'b1;
        end
        rx_shift = '0;
      end
      EDGE_ONE:  rx_shift = (rx_shift >> 1) | ONE_BIT;
      EDGE_ZERO: rx_shift = rx_shift >> 1;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      if (err_cnt < REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      err_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample all handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_ni) begin
      // check a result item against the oldest pending frame
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = frame_result_t'(m_axis_tdata_o[RES_BITS-1:0]);
        if (pending_frames.size() == 0) begin
          if (err_cnt < REPORT_LIMIT)
            $display("%0t: result item %0h with no frame pending", $realtime, m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = pending_frames.pop_front();
          check_field("frame_id",       want.frame_id,       got.frame_id);
          check_field("payload_first",  want.payload_first,  got.payload_first);
          check_field("payload_second", want.payload_second, got.payload_second);
          check_field("payload_third",  want.payload_third,  got.payload_third);
          check_field("checksum_ok",    8'(want.checksum_ok), 8'(got.checksum_ok));
          check_field("is_new",         8'(want.is_new),      8'(got.is_new));
          check_field("ack_byte",       want.ack_byte,       got.ack_byte);
          check_field("ack_twice",      8'(want.ack_twice),   8'(got.ack_twice));
          check_field("tdata padding",  8'h00, 8'(m_axis_tdata_o >> RES_BITS));
        end
      end
      // advance the decoder copy on every accepted interval item
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_interval(s_axis_tdata_i[INTERVAL_BITS-1:0]);
        accepted_cnt <= accepted_cnt + 1;
      end
      // mirror register writes; unknown indexes change nothing
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GAP:   thr.gap   = cfg_data_i;
          CFG_START: thr.start = cfg_data_i;
          CFG_END:   thr.stop  = cfg_data_i;
          CFG_ONE:   thr.one   = cfg_data_i;
          CFG_ZERO:  thr.zero  = cfg_data_i;
          default: ;
        endcase
      end
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offer the next queued interval at the falling edge; hold an item
  // until it is taken, idle only between items
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (interval_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= IN_TDATA_BITS'(interval_q.pop_front());
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack        <= hold_req;
      hold_left       <= LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Pick an interval of the wanted kind under the current thresholds. Where
  // the thresholds leave no room for that kind, fall back to any value.
  function automatic interval_t pick_interval(input mark_e m);
    int unsigned lo;
    int unsigned hi;
    lo = 0;
    hi = IV_MAX;
    case (m)
      MK_GAP:   lo = thr.gap + 1;
      MK_START: lo = thr.start + 1;
      MK_END:   begin lo = thr.stop + 1; hi = thr.start; end
      MK_ONE:   begin lo = thr.one + 1;  hi = lesser(thr.start, thr.stop); end
      MK_ZERO:  begin lo = thr.zero + 1; hi = lesser(lesser(thr.start, thr.stop), thr.one); end
      default:  hi = lesser(lesser(thr.start, thr.stop), lesser(thr.one, thr.zero));
    endcase
    if (lo > hi) return interval_t'($urandom);
    // lean on the range ends so every threshold boundary gets hit
    case ($urandom_range(7))
      0:       return interval_t'(lo);
      1:       return interval_t'(hi);
      default: return interval_t'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic add_item(input interval_t t);
    interval_q.push_back(t);
    pushed_cnt++;
  endtask

  task automatic add_mark(input mark_e m);
    add_item(pick_interval(m));
  endtask

  // One byte, LSB first, closed by an end mark. Now and then drop in short
  // ignored edges, or send too few or too many bits.
  task automatic add_byte(input logic [7:0] v);
    int   nbits;
    logic bitv;
    nbits = ($urandom_range(29) == 0) ? $urandom_range(11) : 8;
    for (int k = 0; k < nbits; k++) begin
      if ($urandom_range(19) == 0) add_mark(MK_LOW);
      if (k < 8) bitv = v[k];
      else       bitv = 1'($urandom);
      if (bitv) add_mark(MK_ONE);
      else      add_mark(MK_ZERO);
    end
    add_mark(MK_END);
  endtask

  // A whole frame: mostly good checksums, ids from a small pool and resends
  // so duplicates occur, sometimes a bad checksum, a missing gap or a cut.
  task automatic add_frame();
    logic [7:0]  b [BYTES_PER_FRAME];
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      b = prev_frame;
    end else begin
      b[0] = (roll < 50) ? 8'($urandom_range(3)) : 8'($urandom);
      for (int i = 1; i < STORE_DEPTH; i++) b[i] = 8'($urandom);
      b[STORE_DEPTH] = b[0] + b[1] + b[2] + b[3];
      if ($urandom_range(99) < 15) b[STORE_DEPTH] ^= 8'($urandom_range(255, 1));
    end
    prev_frame = b;
    if ($urandom_range(9) != 0) add_mark(MK_GAP);
    if ($urandom_range(3) != 0) add_mark(MK_START);
    for (int i = 0; i < BYTES_PER_FRAME; i++) begin
      if ($urandom_range(59) == 0) return;
      add_byte(b[i]);
    end
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1) != 0) add_item(interval_t'($urandom));
      else                        add_mark(mark_e'($urandom_range(int'(MK_LOW))));
    end
  endtask

  // Wait until every item is taken and every frame has come, then let the
  // pipeline drain items that cause no result.
  task automatic settle();
    while (accepted_cnt != pushed_cnt || pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    stop_at = pushed_cnt + budget;
    while (pushed_cnt < stop_at) begin
      if ($urandom_range(99) < 80) add_frame();
      else                         add_noise();
    end
    settle();
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input interval_t value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_thresholds(input interval_t g, input interval_t s, input interval_t e,
                                 input interval_t o, input interval_t z);
    write_reg(CFG_GAP, g);
    write_reg(CFG_START, s);
    write_reg(CFG_END, e);
    write_reg(CFG_ONE, o);
    write_reg(CFG_ZERO, z);
  endtask

  task automatic load_ordered_random();
    interval_t z;
    interval_t o;
    interval_t e;
    interval_t s;
    z = interval_t'($urandom_range(1200, 200));
    o = z + interval_t'($urandom_range(600, 40));
    e = o + interval_t'($urandom_range(600, 40));
    s = e + interval_t'($urandom_range(1500, 40));
    load_thresholds(s + interval_t'($urandom_range(30000)), s, e, o, z);
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    set_idle(7, 82);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes and every threshold boundary under the reset values
    add_item('0);
    add_item(IV_MAX);
    add_item(ZERO_RESET);          // just too short
    add_item(ZERO_RESET + 1'b1);   // zero bit
    add_item(ONE_RESET);           // still a zero bit
    add_item(ONE_RESET + 1'b1);    // one bit
    add_item(END_RESET);           // still a one bit
    add_item(START_RESET + 1'b1);  // start mark
    add_item(GAP_RESET);           // start mark, no gap
    add_item(START_RESET);         // end of byte
    add_item(GAP_RESET + 1'b1);    // frame gap
    // all-zero frame: good checksum, id equals the reset id, so a duplicate
    repeat (BYTES_PER_FRAME) add_item(END_RESET + 1'b1);
    // id 0x80, zero payload, checksum 0x80: a new frame
    add_item(END_RESET);
    repeat (STORE_DEPTH) add_item(END_RESET + 1'b1);
    add_item(END_RESET);
    add_item(END_RESET + 1'b1);
    // id 0x80 with a zero checksum byte: bad checksum
    add_item(END_RESET);
    repeat (BYTES_PER_FRAME) add_item(END_RESET + 1'b1);
    settle();
    run_phase(200);

    // ordered random thresholds; hold the receiver so the block backs up
    load_ordered_random();
    hold_req++;
    run_phase(220);

    // writes to unknown indexes change nothing; a gap that can never occur
    for (int i = int'(CFG_ZERO) + 1; i < (1 << CFG_IDX_BITS); i++)
      write_reg(CFG_IDX_BITS'(i), ($urandom_range(1) != 0) ? IV_MAX : interval_t'($urandom));
    write_reg(CFG_GAP, IV_MAX);
    run_phase(200);

    set_idle(82, 7);
    load_thresholds(GAP_RESET, START_RESET, END_RESET, ONE_RESET, ZERO_RESET);
    run_phase(200);
    // all thresholds at zero: anything nonzero is a gap and a start mark
    load_thresholds('0, '0, '0, '0, '0);
    run_phase(60);
    // all thresholds at the top: every interval is too short
    load_thresholds(IV_MAX, IV_MAX, IV_MAX, IV_MAX, IV_MAX);
    run_phase(60);

    set_idle(0, 0);
    // out-of-order thresholds, used as written
    load_thresholds(interval_t'($urandom_range(4000)), interval_t'($urandom_range(4000)),
                    interval_t'($urandom_range(4000)), interval_t'($urandom_range(4000)),
                    interval_t'($urandom_range(4000)));
    run_phase(200);
    // tightest legal spacing at the bottom of the range
    load_thresholds(interval_t'(4), interval_t'(3), interval_t'(2), interval_t'(1), '0);
    run_phase(200);
    load_ordered_random();
    run_phase(200);
    // tightest spacing at the top of the range
    load_thresholds(IV_MAX - interval_t'(2), IV_MAX - interval_t'(1), IV_MAX - interval_t'(2),
                    IV_MAX - interval_t'(3), IV_MAX - interval_t'(4));
    run_phase(200);

    if (err_cnt == 0 && pending_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/irpd_pkg.sv
rtl/irpd_classify.sv
rtl/ir_pulse_distance_frame_receiver_unit.sv
verif/testbench.sv
